FILE: hw/rtl/cfp_pkg.sv
`default_nettype none
package cfp_pkg;

  localparam int CLAMP_BITS = 40;
  localparam int QUO_W = CLAMP_BITS + 1;
  localparam logic [QUO_W-1:0] CLAMP_MAG = QUO_W'(1) << CLAMP_BITS;

  localparam int SQ_LO_W = 21;
  localparam int SQ_HI_W = QUO_W - SQ_LO_W;
  localparam int SUMSQ_W = 2 * QUO_W;

  localparam int RECIP_W = 64;
  localparam int RECIP_REM_W = RECIP_W + 2;

  localparam int RADICAND_W = 64;
  localparam int ROOT_W = RADICAND_W / 2;
  localparam int ROOT_REM_W = ROOT_W + 2;

endpackage
`default_nettype wire

FILE: hw/rtl/cfp_div_cell.sv
`default_nettype none
module cfp_div_cell #(
  parameter int REM_W = 8,
  parameter int WORD_W = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [REM_W-2:0]  in_dvs,
  input  logic [WORD_W-1:0] in_word,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [REM_W-1:0]  out_rem,
  output logic [REM_W-2:0]  out_dvs,
  output logic [WORD_W-1:0] out_word,
  output logic [SIDE_W-1:0] out_side
);

  logic [REM_W-1:0] shifted;
  logic             take;
  logic [REM_W-1:0] rem_next;
  logic [WORD_W-1:0] word_next;

  // restoring step: remainder stays below the divisor
  assign shifted = {in_rem[REM_W-2:0], in_word[WORD_W-1]};
  assign take = shifted >= {1'b0, in_dvs};
  assign rem_next = take ? shifted - {1'b0, in_dvs} : shifted;
  assign word_next = {in_word[WORD_W-2:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= rem_next;
      out_dvs <= in_dvs;
      out_word <= word_next;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfp_sqrt_cell.sv
`default_nettype none
module cfp_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [cfp_pkg::ROOT_REM_W-1:0] in_rem,
  input  logic [cfp_pkg::ROOT_W-1:0]     in_root,
  input  logic [cfp_pkg::RADICAND_W-1:0] in_word,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [cfp_pkg::ROOT_REM_W-1:0] out_rem,
  output logic [cfp_pkg::ROOT_W-1:0]     out_root,
  output logic [cfp_pkg::RADICAND_W-1:0] out_word,
  output logic [SIDE_W-1:0]              out_side
);

  logic [cfp_pkg::ROOT_REM_W:0]   shifted;
  logic [cfp_pkg::ROOT_REM_W:0]   trial;
  logic                           take;
  logic [cfp_pkg::ROOT_REM_W:0]   diff;

  // one result bit per cell, two radicand bits consumed
  assign shifted = {in_rem[cfp_pkg::ROOT_REM_W-2:0],
                    in_word[cfp_pkg::RADICAND_W-1 -: 2]};
  assign trial = {1'b0, in_root, 2'b01};
  assign take = shifted >= trial;
  assign diff = shifted - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= take ? diff[cfp_pkg::ROOT_REM_W-1:0]
                      : shifted[cfp_pkg::ROOT_REM_W-1:0];
      out_root <= {in_root[cfp_pkg::ROOT_W-2:0], take};
      out_word <= {in_word[cfp_pkg::RADICAND_W-3:0], 2'b00};
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/circle_from_three_points_core.sv
// Circumcircle of three points. One item is taken per clock. Its result passes
// through eight front-end stages (differences, determinant, numerators,
// rounding setup), two rows of 41 divider cells for the center offset,
// four stages that form the center and the squared radius, a row of 64
// divider cells for the reciprocal of the squared radius, 32 square-root
// cells and the output register. The whole pipeline holds while a result waits under out_stall.
// center_x/center_y are Q32.0 and curvature Q0.32, all saturating; a
// degenerate triple gives zeros with degenerate set.
`default_nettype none
module circle_from_three_points_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] middle_x,
  input  logic signed [COORD_WIDTH-1:0] middle_y,
  input  logic signed [COORD_WIDTH-1:0] last_x,
  input  logic signed [COORD_WIDTH-1:0] last_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            center_x,
  output logic signed [31:0]            center_y,
  output logic [31:0]                   curvature,
  output logic                          degenerate
);

  localparam int W = COORD_WIDTH;
  localparam int D = W + 1;
  localparam int SQW = 2 * D - 1;
  localparam int BW = 2 * D;
  localparam int DETW = 2 * D + 1;
  localparam int TDW = DETW + 1;
  localparam int LIMW = 16 + D;
  localparam int CMW = TDW > LIMW ? TDW : LIMW;
  localparam int PPW = 2 * D + 1;
  localparam int TW = 3 * D + 1;
  localparam int NW = TW + 1;
  localparam int NNW = NW + 2;
  localparam int DVW = TDW + 1;
  localparam int RW = DVW + 1;
  localparam int RHSW = DVW + cfp_pkg::CLAMP_BITS + 1;
  localparam int NCW = NNW > RHSW ? NNW : RHSW;
  localparam int NPW = NNW + cfp_pkg::QUO_W;
  localparam int CSW = (W > cfp_pkg::QUO_W + 1 ? W : cfp_pkg::QUO_W + 1) + 1;
  localparam int QW = cfp_pkg::QUO_W;
  localparam int SSW = cfp_pkg::SUMSQ_W;
  localparam int RRW = cfp_pkg::RECIP_REM_W;
  localparam int RQW = cfp_pkg::RECIP_W;

  typedef struct packed {
    logic [W-1:0] fx;
    logic [W-1:0] fy;
    logic         degen;
    logic         negx;
    logic         negy;
    logic         clampx;
  } dside_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        degen;
    logic        sat;
    logic        big;
  } rside_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        degen;
    logic        sat;
  } sside_t;

  localparam int DSW = $bits(dside_t);
  localparam int RSW = $bits(rside_t);
  localparam int SSDW = $bits(sside_t);

  logic en;
  logic [15:0] thr;

  assign en = ~out_valid | ~out_stall;
  assign in_stall = ~en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd1;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // front end
  logic                f0_v, f1_v, f2_v, f3_v, f4_v, f5_v, f6_v, f7_v;
  logic signed [W-1:0] f0_fx, f0_fy, f1_fx, f1_fy, f2_fx, f2_fy, f3_fx, f3_fy;
  logic signed [W-1:0] f4_fx, f4_fy, f5_fx, f5_fy, f6_fx, f6_fy, f7_fx, f7_fy;
  logic signed [D-1:0] f0_bx, f0_by, f0_cx, f0_cy;
  logic signed [D-1:0] f1_bx, f1_by, f1_cx, f1_cy;
  logic signed [D-1:0] f2_bx, f2_by, f2_cx, f2_cy;
  logic signed [2*D-1:0] f1_p1, f1_p2;
  logic signed [2*D-1:0] sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [2*D-1:0] prod1, prod2;
  logic [SQW-1:0]      f1_sbx, f1_sby, f1_scx, f1_scy;
  logic [D-1:0]        f1_abx, f1_aby;
  logic                f1_bzero, f2_bzero;
  logic signed [DETW-1:0] f2_det;
  logic [BW-1:0]       f2_b2, f2_c2;
  logic [LIMW-1:0]     f2_lim;
  logic [D-1:0]        bmax;
  logic signed [TDW-1:0] twodet;
  logic [TDW-1:0]      ad_c;
  logic [TDW-1:0]      f3_ad, f4_ad, f5_ad, f6_ad;
  logic                f3_dneg, f4_dneg, f5_dneg;
  logic                f3_degen, f4_degen, f5_degen, f6_degen, f7_degen;
  logic signed [PPW-1:0] pp_a_h, pp_a_l, pp_b_h, pp_b_l, pp_c_h, pp_c_l, pp_e_h, pp_e_l;
  logic signed [PPW-1:0] f3_ah, f3_al, f3_bh, f3_bl, f3_ch, f3_cl, f3_eh, f3_el;
  logic signed [TW-1:0] f4_a, f4_b, f4_c, f4_e;
  logic signed [NW-1:0] f5_nx, f5_ny;
  logic [NW-1:0]       f6_anx, f6_any;
  logic                f6_negx, f6_negy, f7_negx, f7_negy;
  logic [NNW-1:0]      f7_nx, f7_ny;
  logic [DVW-1:0]      f7_dv;
  logic [RHSW-1:0]     f7_rhs;

  assign sq_bx = f0_bx * f0_bx;
  assign sq_by = f0_by * f0_by;
  assign sq_cx = f0_cx * f0_cx;
  assign sq_cy = f0_cy * f0_cy;
  assign prod1 = f0_bx * f0_cy;
  assign prod2 = f0_by * f0_cx;
  assign bmax = f1_abx > f1_aby ? f1_abx : f1_aby;
  assign twodet = $signed({f2_det, 1'b0});
  assign ad_c = twodet[TDW-1] ? $unsigned(-twodet) : $unsigned(twodet);
  assign pp_a_h = $signed({1'b0, f2_b2[BW-1:D]}) * f2_cy;
  assign pp_a_l = $signed({1'b0, f2_b2[D-1:0]}) * f2_cy;
  assign pp_b_h = $signed({1'b0, f2_c2[BW-1:D]}) * f2_by;
  assign pp_b_l = $signed({1'b0, f2_c2[D-1:0]}) * f2_by;
  assign pp_c_h = $signed({1'b0, f2_c2[BW-1:D]}) * f2_bx;
  assign pp_c_l = $signed({1'b0, f2_c2[D-1:0]}) * f2_bx;
  assign pp_e_h = $signed({1'b0, f2_b2[BW-1:D]}) * f2_cx;
  assign pp_e_l = $signed({1'b0, f2_b2[D-1:0]}) * f2_cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
      f5_v <= 1'b0;
      f6_v <= 1'b0;
      f7_v <= 1'b0;
    end else if (en) begin
      f0_v <= in_valid;
      f1_v <= f0_v;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
      f5_v <= f4_v;
      f6_v <= f5_v;
      f7_v <= f6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_fx <= first_x;
      f0_fy <= first_y;
      f0_bx <= $signed({middle_x[W-1], middle_x}) - $signed({first_x[W-1], first_x});
      f0_by <= $signed({middle_y[W-1], middle_y}) - $signed({first_y[W-1], first_y});
      f0_cx <= $signed({last_x[W-1], last_x}) - $signed({first_x[W-1], first_x});
      f0_cy <= $signed({last_y[W-1], last_y}) - $signed({first_y[W-1], first_y});

      f1_fx <= f0_fx;
      f1_fy <= f0_fy;
      f1_bx <= f0_bx;
      f1_by <= f0_by;
      f1_cx <= f0_cx;
      f1_cy <= f0_cy;
      f1_p1 <= prod1;
      f1_p2 <= prod2;
      f1_sbx <= sq_bx[SQW-1:0];
      f1_sby <= sq_by[SQW-1:0];
      f1_scx <= sq_cx[SQW-1:0];
      f1_scy <= sq_cy[SQW-1:0];
      f1_abx <= f0_bx[D-1] ? $unsigned(-f0_bx) : $unsigned(f0_bx);
      f1_aby <= f0_by[D-1] ? $unsigned(-f0_by) : $unsigned(f0_by);
      f1_bzero <= (f0_bx == '0) && (f0_by == '0);

      f2_fx <= f1_fx;
      f2_fy <= f1_fy;
      f2_bx <= f1_bx;
      f2_by <= f1_by;
      f2_cx <= f1_cx;
      f2_cy <= f1_cy;
      f2_det <= DETW'(f1_p1) - DETW'(f1_p2);
      f2_b2 <= BW'(f1_sbx) + BW'(f1_sby);
      f2_c2 <= BW'(f1_scx) + BW'(f1_scy);
      f2_lim <= LIMW'(thr) * LIMW'(bmax);
      f2_bzero <= f1_bzero;

      f3_fx <= f2_fx;
      f3_fy <= f2_fy;
      f3_ad <= ad_c;
      f3_dneg <= f2_det[DETW-1];
      f3_degen <= f2_bzero || (f2_det == '0) || (CMW'(ad_c) < CMW'(f2_lim));
      f3_ah <= pp_a_h;
      f3_al <= pp_a_l;
      f3_bh <= pp_b_h;
      f3_bl <= pp_b_l;
      f3_ch <= pp_c_h;
      f3_cl <= pp_c_l;
      f3_eh <= pp_e_h;
      f3_el <= pp_e_l;

      f4_fx <= f3_fx;
      f4_fy <= f3_fy;
      f4_ad <= f3_ad;
      f4_dneg <= f3_dneg;
      f4_degen <= f3_degen;
      f4_a <= (TW'(f3_ah) <<< D) + TW'(f3_al);
      f4_b <= (TW'(f3_bh) <<< D) + TW'(f3_bl);
      f4_c <= (TW'(f3_ch) <<< D) + TW'(f3_cl);
      f4_e <= (TW'(f3_eh) <<< D) + TW'(f3_el);

      f5_fx <= f4_fx;
      f5_fy <= f4_fy;
      f5_ad <= f4_ad;
      f5_dneg <= f4_dneg;
      f5_degen <= f4_degen;
      f5_nx <= NW'(f4_a) - NW'(f4_b);
      f5_ny <= NW'(f4_c) - NW'(f4_e);

      f6_fx <= f5_fx;
      f6_fy <= f5_fy;
      f6_ad <= f5_ad;
      f6_degen <= f5_degen;
      f6_anx <= f5_nx[NW-1] ? $unsigned(-f5_nx) : $unsigned(f5_nx);
      f6_any <= f5_ny[NW-1] ? $unsigned(-f5_ny) : $unsigned(f5_ny);
      f6_negx <= f5_nx[NW-1] ^ f5_dneg;
      f6_negy <= f5_ny[NW-1] ^ f5_dneg;

      f7_fx <= f6_fx;
      f7_fy <= f6_fy;
      f7_degen <= f6_degen;
      f7_negx <= f6_negx;
      f7_negy <= f6_negy;
      f7_nx <= (NNW'(f6_anx) << 1) + NNW'(f6_ad);
      f7_ny <= (NNW'(f6_any) << 1) + NNW'(f6_ad);
      f7_dv <= {f6_ad, 1'b0};
      f7_rhs <= (RHSW'(f6_ad) << (cfp_pkg::CLAMP_BITS + 1)) + (RHSW'(f6_ad) << 1);
    end
  end

  // center offset dividers
  logic           dx_v [0:QW];
  logic [RW-1:0]  dx_rem [0:QW];
  logic [RW-2:0]  dx_dv [0:QW];
  logic [QW-1:0]  dx_word [0:QW];
  logic [DSW-1:0] dx_side [0:QW];
  logic           dy_v [0:QW];
  logic [RW-1:0]  dy_rem [0:QW];
  logic [RW-2:0]  dy_dv [0:QW];
  logic [QW-1:0]  dy_word [0:QW];
  logic [0:0]     dy_side [0:QW];
  logic [NPW-1:0] npad_x, npad_y;
  dside_t         dside_in, dside_out;

  assign npad_x = NPW'(f7_nx);
  assign npad_y = NPW'(f7_ny);
  assign dside_in.fx = f7_fx;
  assign dside_in.fy = f7_fy;
  assign dside_in.degen = f7_degen;
  assign dside_in.negx = f7_negx;
  assign dside_in.negy = f7_negy;
  assign dside_in.clampx = NCW'(f7_nx) >= NCW'(f7_rhs);

  assign dx_v[0] = f7_v;
  assign dx_rem[0] = npad_x[QW +: RW];
  assign dx_dv[0] = f7_dv;
  assign dx_word[0] = npad_x[QW-1:0];
  assign dx_side[0] = dside_in;
  assign dy_v[0] = f7_v;
  assign dy_rem[0] = npad_y[QW +: RW];
  assign dy_dv[0] = f7_dv;
  assign dy_word[0] = npad_y[QW-1:0];
  assign dy_side[0] = NCW'(f7_ny) >= NCW'(f7_rhs);

  for (genvar i = 0; i < QW; i++) begin : g_div
    cfp_div_cell #(.REM_W(RW), .WORD_W(QW), .SIDE_W(DSW)) u_cell_x (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dx_v[i]), .in_rem(dx_rem[i]), .in_dvs(dx_dv[i]),
      .in_word(dx_word[i]), .in_side(dx_side[i]),
      .out_valid(dx_v[i+1]), .out_rem(dx_rem[i+1]), .out_dvs(dx_dv[i+1]),
      .out_word(dx_word[i+1]), .out_side(dx_side[i+1])
    );
    cfp_div_cell #(.REM_W(RW), .WORD_W(QW), .SIDE_W(1)) u_cell_y (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dy_v[i]), .in_rem(dy_rem[i]), .in_dvs(dy_dv[i]),
      .in_word(dy_word[i]), .in_side(dy_side[i]),
      .out_valid(dy_v[i+1]), .out_rem(dy_rem[i+1]), .out_dvs(dy_dv[i+1]),
      .out_word(dy_word[i+1]), .out_side(dy_side[i+1])
    );
  end

  assign dside_out = dside_t'(dx_side[QW]);

  // offset, center and squared radius
  logic             e1_v, e2_v, e3_v, e4_v;
  logic [QW-1:0]    e1_magx, e1_magy;
  logic             e1_negx, e1_negy, e1_degen, e2_degen, e3_degen, e4_degen;
  logic signed [W-1:0] e1_fx, e1_fy;
  logic signed [QW:0]  ux, uy;
  logic signed [CSW-1:0] sumx, sumy;
  logic [31:0]      e2_cx, e2_cy, e3_cx, e3_cy, e4_cx, e4_cy;
  logic [2*cfp_pkg::SQ_HI_W-1:0] e2_hhx, e2_hhy;
  logic [QW-1:0]    e2_hlx, e2_hly;
  logic [2*cfp_pkg::SQ_LO_W-1:0] e2_llx, e2_lly;
  logic [SSW-1:0]   e3_sx, e3_sy, e4_s;

  function automatic logic [31:0] sat32(input logic signed [CSW-1:0] v);
    logic [31:0] r;
    if ((&v[CSW-1:31]) || !(|v[CSW-1:31])) begin
      r = v[31:0];
    end else begin
      r = v[CSW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return r;
  endfunction

  assign ux = e1_negx ? -$signed({1'b0, e1_magx}) : $signed({1'b0, e1_magx});
  assign uy = e1_negy ? -$signed({1'b0, e1_magy}) : $signed({1'b0, e1_magy});
  assign sumx = CSW'(e1_fx) + CSW'(ux);
  assign sumy = CSW'(e1_fy) + CSW'(uy);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
    end else if (en) begin
      e1_v <= dx_v[QW];
      e2_v <= e1_v;
      e3_v <= e2_v;
      e4_v <= e3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_magx <= dside_out.clampx ? cfp_pkg::CLAMP_MAG : dx_word[QW];
      e1_magy <= dy_side[QW][0] ? cfp_pkg::CLAMP_MAG : dy_word[QW];
      e1_negx <= dside_out.negx;
      e1_negy <= dside_out.negy;
      e1_fx <= $signed(dside_out.fx);
      e1_fy <= $signed(dside_out.fy);
      e1_degen <= dside_out.degen;

      e2_degen <= e1_degen;
      e2_cx <= sat32(sumx);
      e2_cy <= sat32(sumy);
      e2_hhx <= e1_magx[QW-1 -: cfp_pkg::SQ_HI_W] * e1_magx[QW-1 -: cfp_pkg::SQ_HI_W];
      e2_hlx <= e1_magx[QW-1 -: cfp_pkg::SQ_HI_W] * e1_magx[cfp_pkg::SQ_LO_W-1:0];
      e2_llx <= e1_magx[cfp_pkg::SQ_LO_W-1:0] * e1_magx[cfp_pkg::SQ_LO_W-1:0];
      e2_hhy <= e1_magy[QW-1 -: cfp_pkg::SQ_HI_W] * e1_magy[QW-1 -: cfp_pkg::SQ_HI_W];
      e2_hly <= e1_magy[QW-1 -: cfp_pkg::SQ_HI_W] * e1_magy[cfp_pkg::SQ_LO_W-1:0];
      e2_lly <= e1_magy[cfp_pkg::SQ_LO_W-1:0] * e1_magy[cfp_pkg::SQ_LO_W-1:0];

      e3_degen <= e2_degen;
      e3_cx <= e2_cx;
      e3_cy <= e2_cy;
      e3_sx <= (SSW'(e2_hhx) << (2 * cfp_pkg::SQ_LO_W)) + (SSW'(e2_hlx) << (cfp_pkg::SQ_LO_W + 1))
               + SSW'(e2_llx);
      e3_sy <= (SSW'(e2_hhy) << (2 * cfp_pkg::SQ_LO_W)) + (SSW'(e2_hly) << (cfp_pkg::SQ_LO_W + 1))
               + SSW'(e2_lly);

      e4_degen <= e3_degen;
      e4_cx <= e3_cx;
      e4_cy <= e3_cy;
      e4_s <= e3_sx + e3_sy;
    end
  end

  // reciprocal of squared radius: 2^64 / s
  logic           rv [0:RQW];
  logic [RRW-1:0] rrem [0:RQW];
  logic [RRW-2:0] rdv [0:RQW];
  logic [RQW-1:0] rword [0:RQW];
  logic [RSW-1:0] rsd [0:RQW];
  rside_t         rside_in, rside_out;

  assign rside_in.cx = e4_cx;
  assign rside_in.cy = e4_cy;
  assign rside_in.degen = e4_degen;
  assign rside_in.sat = (e4_s[SSW-1:1] == '0);
  assign rside_in.big = (e4_s[SSW-1:RQW+1] != '0) || (e4_s[RQW] && (e4_s[RQW-1:0] != '0));

  assign rv[0] = e4_v;
  assign rrem[0] = RRW'(1);
  assign rdv[0] = e4_s[RRW-2:0];
  assign rword[0] = '0;
  assign rsd[0] = rside_in;

  for (genvar i = 0; i < RQW; i++) begin : g_recip
    cfp_div_cell #(.REM_W(RRW), .WORD_W(RQW), .SIDE_W(RSW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(rv[i]), .in_rem(rrem[i]), .in_dvs(rdv[i]),
      .in_word(rword[i]), .in_side(rsd[i]),
      .out_valid(rv[i+1]), .out_rem(rrem[i+1]), .out_dvs(rdv[i+1]),
      .out_word(rword[i+1]), .out_side(rsd[i+1])
    );
  end

  assign rside_out = rside_t'(rsd[RQW]);

  // square root
  localparam int NR = cfp_pkg::ROOT_W;
  logic                           sv [0:NR];
  logic [cfp_pkg::ROOT_REM_W-1:0] srem [0:NR];
  logic [cfp_pkg::ROOT_W-1:0]     sroot [0:NR];
  logic [cfp_pkg::RADICAND_W-1:0] sword [0:NR];
  logic [SSDW-1:0]                ssd [0:NR];
  sside_t                         sside_in, sside_out;

  assign sside_in.cx = rside_out.cx;
  assign sside_in.cy = rside_out.cy;
  assign sside_in.degen = rside_out.degen;
  assign sside_in.sat = rside_out.sat;

  assign sv[0] = rv[RQW];
  assign srem[0] = '0;
  assign sroot[0] = '0;
  assign sword[0] = rside_out.big ? '0 : rword[RQW];
  assign ssd[0] = sside_in;

  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    cfp_sqrt_cell #(.SIDE_W(SSDW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[i]), .in_rem(srem[i]), .in_root(sroot[i]),
      .in_word(sword[i]), .in_side(ssd[i]),
      .out_valid(sv[i+1]), .out_rem(srem[i+1]), .out_root(sroot[i+1]),
      .out_word(sword[i+1]), .out_side(ssd[i+1])
    );
  end

  assign sside_out = sside_t'(ssd[NR]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= sside_out.degen;
      center_x <= sside_out.degen ? '0 : $signed(sside_out.cx);
      center_y <= sside_out.degen ? '0 : $signed(sside_out.cy);
      curvature <= sside_out.degen ? '0 : (sside_out.sat ? '1 : sroot[NR]);
    end
  end

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    dx_v[QW] == dy_v[QW])
    else $error("offset divider lanes out of step");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (curvature == '0 && center_x == '0 && center_y == '0))
    else $error("degenerate item with nonzero result");

endmodule
`default_nettype wire

FILE: dv/circle_from_three_points_scoreboard.sv
`default_nettype none
module circle_from_three_points_scoreboard #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] middle_x,
  input  logic signed [COORD_WIDTH-1:0] middle_y,
  input  logic signed [COORD_WIDTH-1:0] last_x,
  input  logic signed [COORD_WIDTH-1:0] last_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [31:0]            center_x,
  input  logic signed [31:0]            center_y,
  input  logic [31:0]                   curvature,
  input  logic                          degenerate,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned OFFSET_LIMIT = 64'd1 << 40;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        curv;
    logic               degen;
  } circle_t;

  circle_t     pending_circles[$];
  logic [15:0] threshold;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rounded_quotient(input longint num, input longint den);
    longint unsigned q;
    q = (2 * mag(num) + mag(den)) / (2 * mag(den));
    if (q > OFFSET_LIMIT) q = OFFSET_LIMIT;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic circle_t circumcircle_of(
    input logic signed [COORD_WIDTH-1:0] ax, ay, mx, my, lx, ly,
    input logic [15:0] thr
  );
    circle_t r;
    longint fx, fy, bx, by, qx, qy, det, twodet, bmax, lim, b2, c2, ux, uy;
    logic [127:0] s, t;
    longint unsigned root;
    fx = ax; fy = ay;
    bx = longint'(mx) - fx; by = longint'(my) - fy;
    qx = longint'(lx) - fx; qy = longint'(ly) - fy;
    det = bx * qy - by * qx;
    twodet = 2 * det;
    bmax = (mag(bx) > mag(by)) ? mag(bx) : mag(by);
    lim = longint'(thr) * bmax;
    r = '0;
    if ((bx == 0 && by == 0) || det == 0 || mag(twodet) < lim) begin
      r.degen = 1'b1;
      return r;
    end
    b2 = bx * bx + by * by;
    c2 = qx * qx + qy * qy;
    ux = rounded_quotient(b2 * qy - c2 * by, twodet);
    uy = rounded_quotient(c2 * bx - b2 * qx, twodet);
    s = 128'(mag(ux)) * 128'(mag(ux)) + 128'(mag(uy)) * 128'(mag(uy));
    if (s == 0) begin
      r.curv = 32'hFFFF_FFFF;
    end else begin
      t = (128'd1 << 64) / s;
      if (t[127:64] != 0) begin
        r.curv = 32'hFFFF_FFFF;
      end else begin
        root = int_sqrt(t[63:0]);
        r.curv = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      end
    end
    r.cx = sat32(fx + ux);
    r.cy = sat32(fy + uy);
    return r;
  endfunction

  always @(posedge clk) begin
    circle_t e;
    int      bad;
    if (rst) begin
      threshold <= 16'd1;
      pending_circles.delete();
      errors <= 0;
    end else begin
      bad = 0;
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (in_valid && !in_stall)
        pending_circles.insert(pending_circles.size(),
                               circumcircle_of(first_x, first_y, middle_x, middle_y,
                                               last_x, last_y, threshold));
      if (out_valid && !out_stall) begin
        if (pending_circles.size() == 0) begin
          $error("result with no item outstanding");
          bad++;
        end else begin
          e = pending_circles.pop_front();
          if (center_x !== e.cx) begin
            $error("center_x: expected %0d, got %0d", e.cx, center_x);
            bad++;
          end
          if (center_y !== e.cy) begin
            $error("center_y: expected %0d, got %0d", e.cy, center_y);
            bad++;
          end
          if (curvature !== e.curv) begin
            $error("curvature: expected %0h, got %0h", e.curv, curvature);
            bad++;
          end
          if (degenerate !== e.degen) begin
            $error("degenerate: expected %0b, got %0b", e.degen, degenerate);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

  assign pending = pending_circles.size();

endmodule
`default_nettype wire

FILE: dv/circle_from_three_points_core_tb.sv
`default_nettype none
module circle_from_three_points_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int PIPE_CYCLES = 160;
  localparam int RANDOM_PER_PHASE = 275;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid, cfg_ready;
  logic [15:0]          cfg_data;
  logic                 in_valid, in_stall;
  logic signed [CW-1:0] first_x, first_y, middle_x, middle_y, last_x, last_y;
  logic                 out_valid, out_stall;
  logic signed [31:0]   center_x, center_y;
  logic [31:0]          curvature;
  logic                 degenerate;
  int                   errors, pending;
  int                   items_sent;
  bit                   long_hold_done;

  always #6 clk = ~clk;

  circle_from_three_points_core #(.COORD_WIDTH(CW)) u_dut (.*);

  circle_from_three_points_scoreboard #(.COORD_WIDTH(CW)) u_scoreboard (.*);

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back the pipeline up
  initial begin
    int mode, len, k;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= 300) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold_done = 1'b1;
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 200);
      for (k = 0; k < len; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 40);
          default: out_stall <= (k % 4 == 3);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_triple(input int ax, ay, mx, my, lx, ly);
    in_valid <= 1'b1;
    first_x <= CW'(ax); first_y <= CW'(ay);
    middle_x <= CW'(mx); middle_y <= CW'(my);
    last_x <= CW'(lx); last_y <= CW'(ly);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int n, burst, ax, ay, dx, dy, k, m;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n < count) begin
        ax = $signed(16'($urandom)); ay = $signed(16'($urandom));
        case ($urandom_range(0, 9))
          0, 1, 2, 3:
            send_triple(ax, ay, $signed(16'($urandom)), $signed(16'($urandom)),
                        $signed(16'($urandom)), $signed(16'($urandom)));
          4, 5:
            send_triple(ax, ay, ax + $urandom_range(0, 128) - 64,
                        ay + $urandom_range(0, 128) - 64,
                        ax + $urandom_range(0, 128) - 64, ay + $urandom_range(0, 128) - 64);
          6, 7: begin
            dx = $urandom_range(0, 400) - 200; dy = $urandom_range(0, 400) - 200;
            k = $urandom_range(0, 20) - 10; m = $urandom_range(0, 20) - 10;
            send_triple(ax, ay, ax + k * dx, ay + k * dy,
                        ax + m * dx + $urandom_range(0, 2) - 1,
                        ay + m * dy + $urandom_range(0, 2) - 1);
          end
          8:
            send_triple(ax, ay, ax, ay, $signed(16'($urandom)), $signed(16'($urandom)));
          default:
            send_triple(ax, ay, ax + $urandom_range(0, 4000) - 2000,
                        ay + $urandom_range(0, 4000) - 2000,
                        ax + $urandom_range(0, 4000) - 2000, ay + $urandom_range(0, 4000) - 2000);
        endcase
        n++;
        burst--;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_data = '0;
    in_valid = 1'b0;
    first_x = '0; first_y = '0; middle_x = '0; middle_y = '0; last_x = '0; last_y = '0;
    items_sent = 0;
    long_hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_threshold(16'd1);

    send_triple(0, 0, 16, 0, 0, 16);
    send_triple(-32768, -32768, 32767, -32768, -32768, 32767);
    send_triple(32767, 32767, -32768, 32767, 32767, -32768);
    send_triple(-32768, -32768, -32768, -32768, -32768, -32768);
    send_triple(32767, 32767, 32767, 32767, 32767, 32767);
    send_triple(100, 200, 100, 200, 300, 400);
    send_triple(0, 0, 16, 16, 32, 32);
    send_triple(0, 0, 16, 16, 32, 33);
    send_triple(0, 0, 1, 0, 0, 1);
    send_triple(0, 0, 1, 0, 2, 1);
    send_triple(0, 0, 32767, 0, -32768, 1);
    send_triple(-32768, 0, 32767, 1, 0, 32767);
    send_triple(5, -7, -5, 7, 7, 5);
    send_triple(0, 0, 2, 0, 1, 1);
    send_triple(-1, -1, 1, 1, 1, -1);
    send_triple(32767, -32768, -32768, 32767, 0, 0);
    send_triple(0, 0, 0, 1, 1, 0);
    send_triple(0, 0, -32768, -32768, 32767, 32767);
    send_triple(1000, 1000, 1001, 1000, 1000, 1001);
    send_triple(0, 0, 3, 4, 4, 3);
    send_random(RANDOM_PER_PHASE);
    drain();

    write_threshold(16'd65535);
    send_triple(0, 0, 16, 0, 0, 16);
    send_triple(-32768, -32768, 32767, -32768, -32768, 32767);
    send_random(RANDOM_PER_PHASE);
    drain();

    write_threshold(16'd0);
    send_triple(0, 0, 16, 16, 32, 32);
    send_triple(0, 0, 1, 0, 2, 1);
    send_random(RANDOM_PER_PHASE);
    drain();

    write_threshold(16'($urandom_range(2, 300)));
    send_random(RANDOM_PER_PHASE);
    drain();

    write_threshold(16'd16);
    send_random(RANDOM_PER_PHASE);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
